[rtl/core/pts_pkg.sv]
// Shared types, constants and helpers of the priority task scheduler.
package pts_pkg;

   localparam int FUNC_W   = 3;
   localparam int ID_W     = 6;
   localparam int PRIO_W   = 2;
   localparam int TICK_W   = 16;
   localparam int NOW_W    = 32;
   localparam int STATUS_W = 2;
   localparam int REM_W    = 7;
   localparam int LVL_W    = 3;

   localparam int FIFO_DEPTH_DEF  = 16;
   localparam int TIMER_DEPTH_DEF = 16;
   localparam int TASK_SLOTS_DEF  = 64;
   localparam int LEVELS_DEF      = 3;

   typedef enum logic [FUNC_W-1:0] {
      FN_SUBMIT   = 3'd0,
      FN_TICK     = 3'd1,
      FN_DISPATCH = 3'd2,
      FN_CANCEL   = 3'd3,
      FN_COMPLETE = 3'd4
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_NONE     = 2'd1,
      ST_BAD_PRIO = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef enum logic {
      TQ_INSERT  = 1'b0,
      TQ_PROMOTE = 1'b1
   } tq_op_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [ID_W-1:0]   task_id;
      logic [PRIO_W-1:0] priority_req;
      logic [TICK_W-1:0] delay;
      logic [TICK_W-1:0] repeat_ticks;
   } req_type;

   typedef struct packed {
      status_type       status;
      logic [ID_W-1:0]  served_id;
      logic             run_it;
      logic [REM_W-1:0] remaining;
      logic             all_done;
   } rsp_type;

   typedef struct packed {
      logic [NOW_W-1:0] due;
      logic [ID_W-1:0]  id;
   } tq_entry_type;

   typedef struct packed {
      logic             start;
      tq_op_type        op;
      logic [NOW_W-1:0] due;
      logic [ID_W-1:0]  id;
   } tq_cmd_type;

   typedef struct packed {
      logic done;
      logic ok;
   } tq_rsp_type;

   typedef struct packed {
      logic             push;
      logic             pop;
      logic [LVL_W-1:0] lvl;
      logic [ID_W-1:0]  id;
   } fifo_cmd_type;

   function automatic logic [NOW_W-1:0] sat_add(input logic [NOW_W-1:0] a,
                                                input logic [NOW_W-1:0] b);
      logic [NOW_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[NOW_W] ? '1 : s[NOW_W-1:0];
   endfunction

endpackage

[rtl/core/pts_if.sv]
// Request and response channel interfaces of the priority task scheduler.
interface pts_req_if;
   logic                       valid;
   logic                       ready;
   logic [pts_pkg::FUNC_W-1:0] func;
   logic [pts_pkg::ID_W-1:0]   task_id;
   logic [pts_pkg::PRIO_W-1:0] priority_req;
   logic [pts_pkg::TICK_W-1:0] delay;
   logic [pts_pkg::TICK_W-1:0] repeat_ticks;

   modport source (output valid, func, task_id, priority_req, delay, repeat_ticks,
                   input ready);
   modport sink (input valid, func, task_id, priority_req, delay, repeat_ticks,
                 output ready);
endinterface

interface pts_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [pts_pkg::STATUS_W-1:0] status;
   logic [pts_pkg::ID_W-1:0]     served_id;
   logic                         run_it;
   logic [pts_pkg::REM_W-1:0]    remaining;
   logic                         all_done;

   modport source (output valid, status, served_id, run_it, remaining, all_done,
                   input ready);
   modport sink (input valid, status, served_id, run_it, remaining, all_done,
                 output ready);
endinterface

[rtl/core/priority_task_scheduler_with_timer_queue.sv]
// Strict-priority task scheduler with a sorted timer queue; one transaction in flight.
// A transaction is taken when req_chan.ready is high and the response is loaded into
// the output register, so the next request can be taken while it waits. Submit without
// delay, tick and cancel pass through the execute and response states; dispatch from a
// non-empty FIFO adds the FIFO read state, and complete adds the interval memory read.
// Delayed submit and repeat re-arm walk the timer queue from its tail with a single-port
// memory and one comparator, reading and then rewriting each entry moved. A dispatch
// with all FIFOs empty promotes due timers into the highest-priority FIFO before serving.
module priority_task_scheduler_with_timer_queue #(
   parameter int FIFO_DEPTH  = pts_pkg::FIFO_DEPTH_DEF,
   parameter int TIMER_DEPTH = pts_pkg::TIMER_DEPTH_DEF,
   parameter int TASK_SLOTS  = pts_pkg::TASK_SLOTS_DEF,
   parameter int LEVELS      = pts_pkg::LEVELS_DEF
) (
   input logic        clock,
   input logic        reset,
   pts_req_if.sink    req_chan,
   pts_rsp_if.source  rsp_chan
);
   import pts_pkg::*;

   localparam int SLOT_W = $clog2(TASK_SLOTS);
   localparam int RC_W   = $clog2(TASK_SLOTS + 1);
   localparam int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int REM_MAX = (1 << REM_W) - 1;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_EXEC  = 8'b00000010,
      S_TQW   = 8'b00000100,
      S_PROMW = 8'b00001000,
      S_POPW  = 8'b00010000,
      S_INTV  = 8'b00100000,
      S_RESP  = 8'b01000000,
      S_SPARE = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   req_type   op_ff, op_in;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff, rsp_valid_in;
   status_type status_ff, status_in;
   logic [ID_W-1:0] served_ff, served_in;
   logic      run_ff, run_in;
   logic      done_ff, done_in;
   logic [NOW_W-1:0] now_ff, now_in;
   logic [RC_W-1:0]  rem_ff, rem_in;
   logic [TASK_SLOTS-1:0] busy_ff, busy_in;
   logic [TASK_SLOTS-1:0] canc_ff, canc_in;
   logic [TASK_SLOTS-1:0] runf_ff, runf_in;
   logic [TICK_W-1:0] intv_mem [TASK_SLOTS];
   logic [TICK_W-1:0] intv_rd_ff;
   logic intv_we, intv_re;

   fifo_cmd_type fcmd;
   tq_cmd_type   tcmd;
   tq_rsp_type   trsp;
   logic [LEVELS-1:0] nonempty, full;
   logic [ID_W-1:0]   fifo_data;
   logic              promo_push;
   logic [ID_W-1:0]   promo_id;

   logic [SLOT_W-1:0] sid, pid, free_idx;
   logic              in_range, any_ready;
   logic [LVL_W-1:0]  top_lvl;
   logic              claim_en, free_en;

   assign sid       = SLOT_W'(op_ff.task_id);
   assign pid       = SLOT_W'(fifo_data);
   assign in_range  = (int'(op_ff.task_id) < TASK_SLOTS);
   assign any_ready = |nonempty;

   always_comb begin
      top_lvl = '0;
      for (int l = 0; l < LEVELS; l++) begin
         if (nonempty[l]) top_lvl = LVL_W'(l);
      end
   end

   pts_fifos #(.FIFO_DEPTH(FIFO_DEPTH), .LEVELS(LEVELS)) u_fifos (
      .clock    (clock),
      .reset    (reset),
      .cmd      (fcmd),
      .nonempty (nonempty),
      .full     (full),
      .rd_data  (fifo_data)
   );

   pts_timerq #(.TIMER_DEPTH(TIMER_DEPTH)) u_timerq (
      .clock      (clock),
      .reset      (reset),
      .cmd        (tcmd),
      .now        (now_ff),
      .high_full  (full[LEVELS-1]),
      .rsp        (trsp),
      .promo_push (promo_push),
      .promo_id   (promo_id)
   );

   assign req_chan.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      served_in    = served_ff;
      run_in       = run_ff;
      done_in      = done_ff;
      now_in       = now_ff;
      rem_in       = rem_ff;
      busy_in      = busy_ff;
      canc_in      = canc_ff;
      runf_in      = runf_ff;
      intv_we      = 1'b0;
      intv_re      = 1'b0;
      fcmd         = '0;
      tcmd         = '0;
      claim_en     = 1'b0;
      free_en      = 1'b0;
      free_idx     = sid;

      if (rsp_valid_ff && rsp_chan.ready) rsp_valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               op_in = '{func: req_chan.func, task_id: req_chan.task_id,
                         priority_req: req_chan.priority_req, delay: req_chan.delay,
                         repeat_ticks: req_chan.repeat_ticks};
               status_in = ST_OK;
               served_in = '0;
               run_in    = 1'b0;
               done_in   = 1'b0;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_RESP;
            case (func_type'(op_ff.func))
               FN_SUBMIT: begin
                  if (int'(op_ff.priority_req) >= LEVELS) begin
                     status_in = ST_BAD_PRIO;
                  end else if (!in_range || busy_ff[sid]) begin
                     status_in = ST_FULL;
                  end else if (op_ff.delay != '0) begin
                     tcmd = '{start: 1'b1, op: TQ_INSERT,
                              due: sat_add(now_ff, NOW_W'(op_ff.delay)), id: op_ff.task_id};
                     state_in = S_TQW;
                  end else if (full[LW'(op_ff.priority_req)]) begin
                     status_in = ST_FULL;
                  end else begin
                     fcmd = '{push: 1'b1, pop: 1'b0, lvl: LVL_W'(op_ff.priority_req),
                              id: op_ff.task_id};
                     claim_en = 1'b1;
                  end
               end
               FN_TICK: now_in = sat_add(now_ff, NOW_W'(1));
               FN_DISPATCH: begin
                  if (any_ready) begin
                     fcmd = '{push: 1'b0, pop: 1'b1, lvl: top_lvl, id: '0};
                     state_in = S_POPW;
                  end else begin
                     tcmd = '{start: 1'b1, op: TQ_PROMOTE, due: '0, id: '0};
                     state_in = S_PROMW;
                  end
               end
               FN_CANCEL: begin
                  if (in_range && busy_ff[sid]) canc_in[sid] = 1'b1;
               end
               FN_COMPLETE: begin
                  if (in_range && busy_ff[sid] && runf_ff[sid]) begin
                     runf_in[sid] = 1'b0;
                     intv_re      = 1'b1;
                     state_in     = S_INTV;
                  end
               end
               default: state_in = S_RESP;
            endcase
         end
         S_TQW: begin
            if (trsp.done) begin
               state_in = S_RESP;
               if (func_type'(op_ff.func) == FN_SUBMIT) begin
                  if (trsp.ok) claim_en = 1'b1;
                  else status_in = ST_FULL;
               end else if (!trsp.ok) begin
                  status_in = ST_FULL;
                  free_en   = 1'b1;
               end
            end
         end
         S_PROMW: begin
            if (promo_push) begin
               fcmd = '{push: 1'b1, pop: 1'b0, lvl: LVL_W'(LEVELS - 1), id: promo_id};
            end else if (trsp.done) begin
               if (any_ready) begin
                  fcmd = '{push: 1'b0, pop: 1'b1, lvl: top_lvl, id: '0};
                  state_in = S_POPW;
               end else begin
                  status_in = ST_NONE;
                  state_in  = S_RESP;
               end
            end
         end
         S_POPW: begin
            served_in = fifo_data;
            if (canc_ff[pid]) begin
               run_in   = 1'b0;
               free_en  = 1'b1;
               free_idx = pid;
            end else begin
               run_in       = 1'b1;
               runf_in[pid] = 1'b1;
            end
            state_in = S_RESP;
         end
         S_INTV: begin
            if (intv_rd_ff != '0 && !canc_ff[sid]) begin
               tcmd = '{start: 1'b1, op: TQ_INSERT,
                        due: sat_add(now_ff, NOW_W'(intv_rd_ff)), id: op_ff.task_id};
               state_in = S_TQW;
            end else begin
               free_en  = 1'b1;
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_in = '{status: status_ff, served_id: served_ff, run_it: run_ff,
                          remaining: (int'(rem_ff) > REM_MAX) ? REM_W'(REM_MAX)
                                                               : REM_W'(rem_ff),
                          all_done: done_ff};
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (claim_en) begin
         busy_in[sid] = 1'b1;
         canc_in[sid] = 1'b0;
         runf_in[sid] = 1'b0;
         intv_we      = 1'b1;
         rem_in       = rem_ff + RC_W'(1);
      end
      if (free_en) begin
         busy_in[free_idx] = 1'b0;
         canc_in[free_idx] = 1'b0;
         runf_in[free_idx] = 1'b0;
         if (rem_ff != '0) begin
            rem_in  = rem_ff - RC_W'(1);
            done_in = (rem_ff == RC_W'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         now_ff       <= '0;
         rem_ff       <= '0;
         busy_ff      <= '0;
         canc_ff      <= '0;
         runf_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         now_ff       <= now_in;
         rem_ff       <= rem_in;
         busy_ff      <= busy_in;
         canc_ff      <= canc_in;
         runf_ff      <= runf_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      rsp_ff    <= rsp_in;
      status_ff <= status_in;
      served_ff <= served_in;
      run_ff    <= run_in;
      done_ff   <= done_in;
   end

   always_ff @(posedge clock) begin
      if (intv_we) begin
         intv_mem[sid] <= op_ff.repeat_ticks;
      end
      if (intv_re) begin
         intv_rd_ff <= intv_mem[sid];
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = rsp_ff.status;
   assign rsp_chan.served_id = rsp_ff.served_id;
   assign rsp_chan.run_it    = rsp_ff.run_it;
   assign rsp_chan.remaining = rsp_ff.remaining;
   assign rsp_chan.all_done  = rsp_ff.all_done;

endmodule

[rtl/core/pts_fifos.sv]
// Bank of per-priority ready FIFOs sharing one memory.
module pts_fifos #(
   parameter int FIFO_DEPTH = pts_pkg::FIFO_DEPTH_DEF,
   parameter int LEVELS     = pts_pkg::LEVELS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  pts_pkg::fifo_cmd_type    cmd,
   output logic [LEVELS-1:0]        nonempty,
   output logic [LEVELS-1:0]        full,
   output logic [pts_pkg::ID_W-1:0] rd_data
);
   import pts_pkg::*;

   localparam int HW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CW = $clog2(FIFO_DEPTH + 1);
   localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int AW = $clog2(LEVELS * FIFO_DEPTH);

   logic [ID_W-1:0] fifo_mem [LEVELS*FIFO_DEPTH];
   logic [HW-1:0]   head_ff [LEVELS];
   logic [HW-1:0]   head_in [LEVELS];
   logic [CW-1:0]   cnt_ff [LEVELS];
   logic [CW-1:0]   cnt_in [LEVELS];
   logic [ID_W-1:0] rd_data_ff;
   logic [LW-1:0]   lvl;
   logic [HW:0]     pos_sum;
   logic [HW:0]     nxt_sum;
   logic [HW-1:0]   wr_pos;
   logic [HW-1:0]   nxt_head;
   logic [AW-1:0]   wr_addr;
   logic [AW-1:0]   rd_addr;

   assign lvl = cmd.lvl[LW-1:0];

   always_comb begin
      pos_sum = (HW+1)'(head_ff[lvl]) + (HW+1)'(cnt_ff[lvl]);
      if (pos_sum >= (HW+1)'(FIFO_DEPTH)) begin
         pos_sum = pos_sum - (HW+1)'(FIFO_DEPTH);
      end
      wr_pos = pos_sum[HW-1:0];
      nxt_sum = (HW+1)'(head_ff[lvl]) + (HW+1)'(1);
      nxt_head = (nxt_sum >= (HW+1)'(FIFO_DEPTH)) ? '0 : nxt_sum[HW-1:0];
      wr_addr = AW'(int'(lvl) * FIFO_DEPTH + int'(wr_pos));
      rd_addr = AW'(int'(lvl) * FIFO_DEPTH + int'(head_ff[lvl]));
   end

   always_comb begin
      for (int l = 0; l < LEVELS; l++) begin
         head_in[l]  = head_ff[l];
         cnt_in[l]   = cnt_ff[l];
         nonempty[l] = (cnt_ff[l] != '0);
         full[l]     = (cnt_ff[l] == CW'(FIFO_DEPTH));
      end
      if (cmd.push) begin
         cnt_in[lvl] = cnt_ff[lvl] + CW'(1);
      end else if (cmd.pop) begin
         cnt_in[lvl]  = cnt_ff[lvl] - CW'(1);
         head_in[lvl] = nxt_head;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < LEVELS; l++) begin
            head_ff[l] <= '0;
            cnt_ff[l]  <= '0;
         end
      end else begin
         head_ff <= head_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         fifo_mem[wr_addr] <= cmd.id;
      end
      if (cmd.pop) begin
         rd_data_ff <= fifo_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/pts_timerq.sv]
// Sorted timer queue: circular memory walked by one due-time comparator.
module pts_timerq #(
   parameter int TIMER_DEPTH = pts_pkg::TIMER_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  pts_pkg::tq_cmd_type       cmd,
   input  logic [pts_pkg::NOW_W-1:0] now,
   input  logic                      high_full,
   output pts_pkg::tq_rsp_type       rsp,
   output logic                      promo_push,
   output logic [pts_pkg::ID_W-1:0]  promo_id
);
   import pts_pkg::*;

   localparam int IW = $clog2(TIMER_DEPTH);
   localparam int CW = $clog2(TIMER_DEPTH + 1);

   typedef enum logic [2:0] {
      TQ_IDLE = 3'b001,
      TQ_RD   = 3'b010,
      TQ_CMP  = 3'b100
   } tq_state_type;

   tq_state_type state_ff, state_in;
   tq_op_type    op_ff, op_in;
   logic [NOW_W-1:0] key_ff, key_in;
   logic [ID_W-1:0]  kid_ff, kid_in;
   logic [CW-1:0]    idx_ff, idx_in;
   logic [IW-1:0]    head_ff, head_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   tq_rsp_type       rsp_ff, rsp_in;
   tq_entry_type     tq_mem [TIMER_DEPTH];
   tq_entry_type     entry_ff;
   tq_entry_type     wr_data;
   logic             wr_en, rd_en;
   logic [CW-1:0]    kx;
   logic [IW-1:0]    addr;
   logic [NOW_W-1:0] key_sel;
   logic             gt;

   function automatic logic [IW-1:0] phys(input logic [IW-1:0] h, input logic [CW-1:0] k);
      logic [IW:0] s;
      s = (IW+1)'(h) + (IW+1)'(k);
      if (s >= (IW+1)'(TIMER_DEPTH)) begin
         s = s - (IW+1)'(TIMER_DEPTH);
      end
      return s[IW-1:0];
   endfunction

   assign key_sel = (op_ff == TQ_INSERT) ? key_ff : now;
   assign gt      = (entry_ff.due > key_sel);
   assign addr    = phys(head_ff, kx);

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      key_in     = key_ff;
      kid_in     = kid_ff;
      idx_in     = idx_ff;
      head_in    = head_ff;
      cnt_in     = cnt_ff;
      rsp_in     = '0;
      wr_en      = 1'b0;
      rd_en      = 1'b0;
      wr_data    = '{due: key_ff, id: kid_ff};
      kx         = idx_ff;
      promo_push = 1'b0;
      promo_id   = entry_ff.id;
      case (state_ff)
         TQ_IDLE: begin
            if (cmd.start) begin
               op_in  = cmd.op;
               key_in = cmd.due;
               kid_in = cmd.id;
               idx_in = cnt_ff;
               if (cmd.op == TQ_INSERT && cnt_ff == CW'(TIMER_DEPTH)) begin
                  rsp_in = '{done: 1'b1, ok: 1'b0};
               end else begin
                  state_in = TQ_RD;
               end
            end
         end
         TQ_RD: begin
            if (op_ff == TQ_INSERT) begin
               if (idx_ff == '0) begin
                  wr_en    = 1'b1;
                  cnt_in   = cnt_ff + CW'(1);
                  rsp_in   = '{done: 1'b1, ok: 1'b1};
                  state_in = TQ_IDLE;
               end else begin
                  kx       = idx_ff - CW'(1);
                  rd_en    = 1'b1;
                  state_in = TQ_CMP;
               end
            end else begin
               kx = '0;
               if (cnt_ff == '0 || high_full) begin
                  rsp_in   = '{done: 1'b1, ok: 1'b1};
                  state_in = TQ_IDLE;
               end else begin
                  rd_en    = 1'b1;
                  state_in = TQ_CMP;
               end
            end
         end
         TQ_CMP: begin
            if (op_ff == TQ_INSERT) begin
               wr_en = 1'b1;
               if (gt) begin
                  wr_data  = entry_ff;
                  idx_in   = idx_ff - CW'(1);
                  state_in = TQ_RD;
               end else begin
                  cnt_in   = cnt_ff + CW'(1);
                  rsp_in   = '{done: 1'b1, ok: 1'b1};
                  state_in = TQ_IDLE;
               end
            end else begin
               if (!gt) begin
                  promo_push = 1'b1;
                  head_in    = phys(head_ff, CW'(1));
                  cnt_in     = cnt_ff - CW'(1);
                  state_in   = TQ_RD;
               end else begin
                  rsp_in   = '{done: 1'b1, ok: 1'b1};
                  state_in = TQ_IDLE;
               end
            end
         end
         default: state_in = TQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= TQ_IDLE;
         head_ff  <= '0;
         cnt_ff   <= '0;
         rsp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         cnt_ff   <= cnt_in;
         rsp_ff   <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      key_ff <= key_in;
      kid_ff <= kid_in;
      idx_ff <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tq_mem[addr] <= wr_data;
      end
      if (rd_en) begin
         entry_ff <= tq_mem[addr];
      end
   end

   assign rsp = rsp_ff;

endmodule

[rtl/core/pts_checker.sv]
// Port-level assertions for the priority task scheduler, bound to the top level.
module pts_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [pts_pkg::STATUS_W-1:0] status,
   input logic [pts_pkg::ID_W-1:0]     served_id,
   input logic                         run_it,
   input logic [pts_pkg::REM_W-1:0]    remaining,
   input logic                         all_done
);
   import pts_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a transaction is in flight");

   a_done_means_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && all_done |-> remaining == '0)
      else $error("all_done with tasks still remaining");

   a_served_means_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (run_it || served_id != '0) |-> status == ST_OK)
      else $error("served task reported with a failing status");

endmodule

bind priority_task_scheduler_with_timer_queue pts_checker u_pts_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .status    (rsp_chan.status),
   .served_id (rsp_chan.served_id),
   .run_it    (rsp_chan.run_it),
   .remaining (rsp_chan.remaining),
   .all_done  (rsp_chan.all_done)
);
